FILE: src/flash_page_map_update_assert.svh
// assertion macros for the page map block and its checker
`ifndef FLASH_PAGE_MAP_UPDATE_ASSERT_SVH
`define FLASH_PAGE_MAP_UPDATE_ASSERT_SVH

// same-cycle implication, held off during reset
`define FPMU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define FPMU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fpmu_pkg.sv
// shared types and constants of the page map block
package fpmu_pkg;

    localparam int CMD_W     = 2;
    localparam int LPAGE_W   = 16;
    localparam int PPAGE_W   = 16;
    localparam int RES_W     = 10;
    localparam int CNT_W     = 11;
    localparam int CMP_W     = LPAGE_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_LOGICAL_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PHYSICAL_COUNT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_BAD = 2'd0,
        CMD_APPLY   = 2'd1,
        CMD_LOOKUP  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_INVAL,
        ST_WRITE
    } seq_state_t;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        logic             done;
        logic             status;
        logic [RES_W-1:0] page;
        logic             page_valid;
    } fpmu_res_t;

endpackage

FILE: src/fpmu_if.sv
// request and response channel interfaces of the page map block
interface fpmu_req_if import fpmu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [LPAGE_W-1:0] log_page;
    logic [PPAGE_W-1:0] phys_page;
    logic               bad_flag;

    modport source (output valid, cmd, log_page, phys_page, bad_flag, input ready);
    modport sink   (input valid, cmd, log_page, phys_page, bad_flag, output ready);
endinterface

interface fpmu_rsp_if import fpmu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic [RES_W-1:0] result_page;
    logic             result_valid;

    modport source (output valid, status, result_page, result_valid, input ready);
    modport sink   (input valid, status, result_page, result_valid, output ready);
endinterface

FILE: src/fpmu_ram.sv
// generic single-port-write, single-port-read ram with registered read
module fpmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/fpmu_seq.sv
// map memories and the read-modify-write sequencer that serves each word
module fpmu_seq import fpmu_pkg::*; #(
    parameter int MAX_PAGES = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    fpmu_req_if.sink         req,
    input  logic [CMP_W-1:0] lc,
    input  logic [CMP_W-1:0] pc,
    input  logic             slot_free,
    output fpmu_res_t        res
);

    localparam int AW    = $clog2(MAX_PAGES);
    localparam int FW    = AW + 1;          // {valid, physical page}
    localparam int RW    = AW + 2;          // {bad, valid, logical page}
    localparam int F_V   = AW;
    localparam int R_V   = AW;
    localparam int R_B   = AW + 1;
    localparam int EXT_W = (AW > RES_W) ? AW : RES_W;
    localparam logic [AW-1:0] LAST = AW'(MAX_PAGES - 1);

    seq_state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic [CMD_W-1:0] cmd_reg;
    logic [AW-1:0]    l_reg;
    logic [AW-1:0]    p_reg;
    logic             flag_reg;
    logic             l_ok_reg;
    logic             p_ok_reg;
    logic [FW-1:0]    old_reg;

    logic          fwd_we, fwd_re, rev_we, rev_re;
    logic [AW-1:0] fwd_waddr, fwd_raddr, rev_waddr, rev_raddr;
    logic [FW-1:0] fwd_wdata, fwd_rdata;
    logic [RW-1:0] rev_wdata, rev_rdata;

    logic             accept;
    logic [EXT_W-1:0] fwd_ext;
    logic [EXT_W-1:0] old_ext;
    logic             inval_hit;

    fpmu_ram #(.WIDTH(FW), .DEPTH(MAX_PAGES)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .re    (fwd_re),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    fpmu_ram #(.WIDTH(RW), .DEPTH(MAX_PAGES)) u_rev_ram (
        .clk   (clk),
        .we    (rev_we),
        .waddr (rev_waddr),
        .wdata (rev_wdata),
        .re    (rev_re),
        .raddr (rev_raddr),
        .rdata (rev_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign fwd_ext = EXT_W'(fwd_rdata[AW-1:0]);
    assign old_ext = EXT_W'(old_reg[AW-1:0]);

    // old page still points back to this logical page
    assign inval_hit = old_reg[F_V]
                    && (CMP_W'(old_reg[AW-1:0]) < pc)
                    && (old_reg[AW-1:0] != p_reg)
                    && rev_rdata[R_V]
                    && (rev_rdata[AW-1:0] == l_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.cmd;
            l_reg    <= req.log_page[AW-1:0];
            p_reg    <= req.phys_page[AW-1:0];
            flag_reg <= req.bad_flag;
            l_ok_reg <= (CMP_W'(req.log_page) < lc);
            p_ok_reg <= (CMP_W'(req.phys_page) < pc);
        end
        if (state_reg == ST_EVAL)
        begin
            old_reg <= fwd_rdata;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        fwd_we        = 1'b0;
        fwd_re        = 1'b0;
        fwd_waddr     = l_reg;
        fwd_wdata     = {1'b1, p_reg};
        fwd_raddr     = req.log_page[AW-1:0];
        rev_we        = 1'b0;
        rev_re        = 1'b0;
        rev_waddr     = p_reg;
        rev_wdata     = {1'b0, 1'b1, l_reg};
        rev_raddr     = req.phys_page[AW-1:0];
        res           = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                fwd_we        = 1'b1;
                rev_we        = 1'b1;
                fwd_waddr     = clr_addr_reg;
                rev_waddr     = clr_addr_reg;
                fwd_wdata     = '0;
                rev_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    fwd_re     = 1'b1;
                    rev_re     = 1'b1;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_SET_BAD:
                    begin
                        if (slot_free)
                        begin
                            res.done   = 1'b1;
                            res.status = !p_ok_reg;
                            rev_we     = p_ok_reg;
                            rev_wdata  = {flag_reg, rev_rdata[R_V], rev_rdata[AW-1:0]};
                            state_next = ST_IDLE;
                        end
                    end

                    CMD_APPLY:
                    begin
                        if (!l_ok_reg || !p_ok_reg || rev_rdata[R_B])
                        begin
                            if (slot_free)
                            begin
                                res.done   = 1'b1;
                                res.status = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            // forward entry now, fetch the old page's reverse entry
                            fwd_we     = 1'b1;
                            rev_re     = 1'b1;
                            rev_raddr  = fwd_rdata[AW-1:0];
                            state_next = ST_INVAL;
                        end
                    end

                    CMD_LOOKUP:
                    begin
                        if (slot_free)
                        begin
                            res.done   = 1'b1;
                            res.status = !l_ok_reg;
                            if (l_ok_reg && fwd_rdata[F_V])
                            begin
                                res.page       = fwd_ext[RES_W-1:0];
                                res.page_valid = 1'b1;
                            end
                            state_next = ST_IDLE;
                        end
                    end

                    default:
                    begin
                        if (slot_free)
                        begin
                            res.done   = 1'b1;
                            res.status = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_INVAL:
            begin
                rev_we     = inval_hit;
                rev_waddr  = old_reg[AW-1:0];
                rev_wdata  = {rev_rdata[R_B], 1'b0, rev_rdata[AW-1:0]};
                state_next = ST_WRITE;
            end

            ST_WRITE:
            begin
                if (slot_free)
                begin
                    rev_we     = 1'b1;
                    res.done   = 1'b1;
                    if (old_reg[F_V])
                    begin
                        res.page       = old_ext[RES_W-1:0];
                        res.page_valid = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/flash_page_map_update.sv
// Page map of a flash translation layer: a forward map (logical to physical
// page), a reverse map (physical to logical page) and a bad flag per physical
// page, all held in two synchronous rams. After reset the block sweeps both
// rams once, one entry a cycle, and takes no word until the sweep is done;
// configuration writes are taken throughout. A bad flag write, a lookup, a
// refused word or an unknown command is a ram read, then an evaluate step
// that writes back only an in-range bad flag; an accepted journal entry is a
// chain of dependent ram accesses: read the forward entry, read the old
// page's reverse entry, invalidate it, write the new reverse entry.
// One word is worked on at a time. The result goes to an output register, so
// the next word is taken while a result waits; the sequencer only holds its
// final step when that register is still full. Counts above MAX_PAGES act as
// MAX_PAGES.
module flash_page_map_update import fpmu_pkg::*; #(
    parameter int MAX_PAGES = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    fpmu_req_if.sink             req,
    fpmu_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_PAGES);

    // configuration registers
    logic [CNT_W-1:0] logical_count_reg;
    logic [CNT_W-1:0] physical_count_reg;

    // effective counts, capped at the store size
    logic [CMP_W-1:0] lc_eff;
    logic [CMP_W-1:0] pc_eff;

    // output register
    logic             out_valid_reg;
    logic             out_status_reg;
    logic [RES_W-1:0] out_page_reg;
    logic             out_pvalid_reg;

    logic      slot_free;
    fpmu_res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            logical_count_reg  <= COUNT_RESET;
            physical_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOGICAL_COUNT:  logical_count_reg  <= cfg_data;
                REG_PHYSICAL_COUNT: physical_count_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign lc_eff = (CMP_W'(logical_count_reg) > MAX_CNT) ? MAX_CNT
                                                          : CMP_W'(logical_count_reg);
    assign pc_eff = (CMP_W'(physical_count_reg) > MAX_CNT) ? MAX_CNT
                                                           : CMP_W'(physical_count_reg);

    // output register is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || rsp.ready;

    fpmu_seq #(.MAX_PAGES(MAX_PAGES)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .lc        (lc_eff),
        .pc        (pc_eff),
        .slot_free (slot_free),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded only when the sequencer finishes a word
    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            out_status_reg <= res.status;
            out_page_reg   <= res.page;
            out_pvalid_reg <= res.page_valid;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_page  = out_page_reg;
    assign rsp.result_valid = out_pvalid_reg;

endmodule

FILE: src/fpmu_checker.sv
// port-level checker of the page map block and its bind
`include "flash_page_map_update_assert.svh"

module fpmu_checker import fpmu_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_status,
    input logic [RES_W-1:0] rsp_result_page,
    input logic             rsp_result_valid
);

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // words taken but whose result has not left yet
    always_comb
    begin
        pend_next = pend_reg;
        if (req_acc && !rsp_acc)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!req_acc && rsp_acc)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `FPMU_ASSERT_NOW(a_no_extra_result, clk, rst_n, rsp_valid, pend_reg != 2'd0, "result without a word")
    `FPMU_ASSERT_NOW(a_pend_bound, clk, rst_n, 1'b1, pend_reg != 2'd3, "more than two words in flight")
    `FPMU_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_acc, !req_ready, "word taken while busy")
    `FPMU_ASSERT_NOW(a_empty_page, clk, rst_n, rsp_valid && (rsp_status || !rsp_result_valid), rsp_result_page == '0 && !rsp_result_valid || rsp_result_page == '0, "page set without mapping")
    `FPMU_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_page), "result dropped while stalled")

endmodule

bind flash_page_map_update fpmu_checker u_fpmu_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_result_page  (rsp.result_page),
    .rsp_result_valid (rsp.result_valid)
);
